@@ rtl/salru_pkg.sv @@
// salru_pkg: shared constants, types and request modes for the LRU tag array
// no dependencies; used by the interfaces, the way logic, the top level, the checker and the bench
package salru_pkg;

    // geometry
    localparam int WAYS_DEF    = 4;
    localparam int SETS        = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int ADDR_BITS   = 32;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int SET_W       = $clog2(SETS);
    localparam int TAG_W       = ADDR_BITS - OFF_W;

    // field widths on the channels
    localparam int MODE_W    = 2;
    localparam int WAY_IDX_W = 2;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [TAG_W-1:0]     tag_t;
    typedef logic [SET_W-1:0]     set_t;
    typedef logic [WAY_IDX_W-1:0] way_idx_t;

    // request modes; the spare code behaves as a lookup
    localparam mode_t MODE_READ   = 2'd0;
    localparam mode_t MODE_LOOKUP = 2'd1;
    localparam mode_t MODE_WRITE  = 2'd2;

    // decision of the way logic for one item
    typedef struct packed {
        logic hit;
        logic lru_we;
        logic tag_we;
    } salru_ctl_t;

endpackage

@@ rtl/salru_if.sv @@
// salru_req_if / salru_rsp_if: valid-ready channels for requests and results
// depends on salru_pkg
interface salru_req_if;
    import salru_pkg::*;

    logic                 valid;
    logic                 ready;
    mode_t                mode;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

interface salru_rsp_if;
    import salru_pkg::*;

    logic     valid;
    logic     ready;
    logic     hit;
    way_idx_t way_index;

    modport source (output valid, output hit, output way_index, input ready);
    modport sink   (input valid, input hit, input way_index, output ready);
endinterface

@@ rtl/set_assoc_lru_tag_array.sv @@
// set_assoc_lru_tag_array: set-associative tag array with true LRU replacement
// depends on salru_pkg, salru_if (salru_req_if, salru_rsp_if) and salru_way_logic
//
// Usage
//   req channel carries mode and byte address; rsp channel returns hit and
//   way_index, one result item per request item, in request order.
//   mode read: search the set, on a hit make that way most recent.
//   mode lookup (and the spare code): search only, no state change.
//   mode write: allocate the least recent way, store the tag, mark it valid and most recent.
// Timing
//   one item per cycle sustained while rsp is ready. The tag and recency
//   memories are read into registers at the accept edge; the compare stage
//   then compares, reorders and writes back, and its result lands in the
//   output register when that stage fires. A write back to a set read
//   by the item right behind it is forwarded, so no bubble is inserted.
// Reset
//   all valid bits clear, every set takes the order way 0 oldest and the
//   highest way newest (through per-set flags, no clearing pass). Ready
//   is high already while reset is asserted.
// Stalls
//   when rsp is not ready the output register holds, one more item may sit
//   in the compare stage, and then req ready drops until rsp drains.
module set_assoc_lru_tag_array #(
    parameter int WAYS = salru_pkg::WAYS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    salru_req_if.sink    req,
    salru_rsp_if.source  rsp
);
    import salru_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef logic [WAYS-1:0][WAY_W-1:0] order_t;

    // recency order of a set that was never touched
    function automatic order_t reset_order();
        order_t o;
        for (int k = 0; k < WAYS; k++)
            o[k] = WAY_W'(WAYS - 1 - k);
        return o;
    endfunction

    // memories
    tag_t   tag_mem [SETS][WAYS];
    order_t lru_mem [SETS];

    // per-entry valid bits and per-set recency flags
    logic [WAYS-1:0] valid_reg [SETS];
    logic [SETS-1:0] lru_ok_reg;

    // read data and compare stage
    tag_t [WAYS-1:0] tag_rd_reg;
    order_t          lru_rd_reg;
    logic            s1_valid_reg;
    mode_t           s1_mode_reg;
    tag_t            s1_tag_reg;

    // write made at the edge the compare-stage item was read
    logic             fwd_lru_en_reg;
    logic             fwd_tag_en_reg;
    set_t             fwd_set_reg;
    logic [WAY_W-1:0] fwd_way_reg;
    order_t           fwd_order_reg;
    tag_t             fwd_tag_reg;

    // output register
    logic     out_valid_reg;
    logic     out_hit_reg;
    way_idx_t out_way_reg;

    logic             in_accept;
    logic             s1_go;
    logic             s1_fire;
    set_t             in_set;
    tag_t             in_tag;
    set_t             s1_set;
    logic             fwd_match;
    order_t           order_cur;
    order_t           order_new;
    tag_t [WAYS-1:0]  tag_cur;
    logic [WAYS-1:0]  valid_cur;
    salru_ctl_t       s1_ctl;
    logic [WAY_W-1:0] s1_way;

    // address split
    assign in_tag = req.address[ADDR_BITS-1:OFF_W];
    assign in_set = in_tag[SET_W-1:0];
    assign s1_set = s1_tag_reg[SET_W-1:0];

    // handshakes
    assign s1_go     = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && s1_go;
    assign req.ready = !s1_valid_reg || s1_go;
    assign in_accept = req.valid && req.ready;

    // current view of the set with forwarding of the previous write back
    assign fwd_match = (fwd_set_reg == s1_set);
    assign valid_cur = valid_reg[s1_set];

    always_comb
    begin
        if (fwd_lru_en_reg && fwd_match)
            order_cur = fwd_order_reg;
        else if (lru_ok_reg[s1_set])
            order_cur = lru_rd_reg;
        else
            order_cur = reset_order();
    end

    always_comb
    begin
        tag_cur = tag_rd_reg;
        if (fwd_tag_en_reg && fwd_match)
            tag_cur[fwd_way_reg] = fwd_tag_reg;
    end

    // compare and reorder
    salru_way_logic #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_way_logic (
        .mode      (s1_mode_reg),
        .tag       (s1_tag_reg),
        .tag_row   (tag_cur),
        .valid_row (valid_cur),
        .order_in  (order_cur),
        .ctl       (s1_ctl),
        .way       (s1_way),
        .order_out (order_new)
    );

    // memory reads, write backs and payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int w = 0; w < WAYS; w++)
                tag_rd_reg[w] <= tag_mem[in_set][w];
            lru_rd_reg    <= lru_mem[in_set];
            s1_mode_reg   <= req.mode;
            s1_tag_reg    <= in_tag;
            fwd_set_reg   <= s1_set;
            fwd_way_reg   <= s1_way;
            fwd_order_reg <= order_new;
            fwd_tag_reg   <= s1_tag_reg;
        end
        if (s1_fire && s1_ctl.tag_we)
            tag_mem[s1_set][s1_way] <= s1_tag_reg;
        if (s1_fire && s1_ctl.lru_we)
            lru_mem[s1_set] <= order_new;
        if (s1_fire)
        begin
            out_hit_reg <= s1_ctl.hit;
            out_way_reg <= WAY_IDX_W'(s1_way);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_lru_en_reg <= 1'b0;
            fwd_tag_en_reg <= 1'b0;
            lru_ok_reg     <= '0;
            for (int s = 0; s < SETS; s++)
                valid_reg[s] <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg   <= 1'b1;
                fwd_lru_en_reg <= s1_fire && s1_ctl.lru_we;
                fwd_tag_en_reg <= s1_fire && s1_ctl.tag_we;
            end
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (s1_fire && s1_ctl.tag_we)
                valid_reg[s1_set][s1_way] <= 1'b1;
            if (s1_fire && s1_ctl.lru_we)
                lru_ok_reg[s1_set] <= 1'b1;
        end
    end

    // result channel
    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.way_index = out_way_reg;

endmodule

@@ rtl/salru_way_logic.sv @@
// salru_way_logic: tag compare across the ways of one set and true LRU reorder
// depends on salru_pkg; instantiated by set_assoc_lru_tag_array
module salru_way_logic #(
    parameter int WAYS  = salru_pkg::WAYS_DEF,
    parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  salru_pkg::mode_t                 mode,
    input  salru_pkg::tag_t                  tag,
    input  salru_pkg::tag_t [WAYS-1:0]       tag_row,
    input  logic [WAYS-1:0]                  valid_row,
    input  logic [WAYS-1:0][WAY_W-1:0]       order_in,
    output salru_pkg::salru_ctl_t            ctl,
    output logic [WAY_W-1:0]                 way,
    output logic [WAYS-1:0][WAY_W-1:0]       order_out
);
    import salru_pkg::*;

    logic             hit_found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
    logic [WAY_W-1:0] touch_way;
    logic             is_write;
    logic             seen;

    // lowest matching valid way wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_way   = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (valid_row[i] && (tag_row[i] == tag))
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(i);
            end
        end
    end

    // least recent way sits at the last position
    assign victim    = order_in[WAYS-1];
    assign is_write  = (mode == MODE_WRITE);
    assign touch_way = is_write ? victim : hit_way;

    // move the touched way to the front, entries ahead of it shift back by one
    always_comb
    begin
        order_out[0] = touch_way;
        seen         = (order_in[0] == touch_way);
        for (int q = 1; q < WAYS; q++)
        begin
            order_out[q] = seen ? order_in[q] : order_in[q-1];
            seen         = seen || (order_in[q] == touch_way);
        end
    end

    // result and write enables
    always_comb
    begin
        ctl.hit    = is_write || hit_found;
        ctl.lru_we = is_write || ((mode == MODE_READ) && hit_found);
        ctl.tag_we = is_write;
        if (is_write)
            way = victim;
        else if (hit_found)
            way = hit_way;
        else
            way = '0;
    end

endmodule

@@ rtl/salru_checker.sv @@
// salru_checker: port-level checks on set_assoc_lru_tag_array, with its bind
// depends on salru_pkg and the top level set_assoc_lru_tag_array
module salru_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic                rsp_hit,
    input salru_pkg::way_idx_t rsp_way_index
);
    import salru_pkg::*;

    logic [1:0] pend_reg;

    // items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end

    // at most one item in compare and one in the output register
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two items in flight");

    // no result without a pending item
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result without a pending item");

    // a miss reports way zero
    a_miss_way: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_way_index == '0)
        else $error("miss with nonzero way");

    // full pipe under backpressure must refuse new items
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 && !rsp_ready |-> !req_ready)
        else $error("item accepted while both stages full");

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_way_index))
        else $error("stalled result changed");

endmodule

bind set_assoc_lru_tag_array salru_checker u_salru_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_hit       (rsp.hit),
    .rsp_way_index (rsp.way_index)
);

@@ test/tb_set_assoc_lru_tag_array.sv @@
// tb_set_assoc_lru_tag_array: self-checking bench for the set-associative LRU tag array
// depends on salru_pkg, salru_req_if / salru_rsp_if and set_assoc_lru_tag_array
// predicts hit and way for each request item and compares every result item in order
module tb_set_assoc_lru_tag_array;
    import salru_pkg::*;

    localparam int NWAYS = WAYS_DEF;
    localparam int HOT_SETS = 8;
    localparam mode_t MODE_SPARE = 2'd3;

    typedef struct packed {
        logic     hit;
        way_idx_t way;
    } tag_result_t;

    logic clk;
    logic rst_n;

    salru_req_if req_ch ();
    salru_rsp_if rsp_ch ();

    set_assoc_lru_tag_array uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the tag array
    tag_t     shadow_tag[NWAYS][SETS];
    logic     shadow_valid[NWAYS][SETS];
    way_idx_t recency[SETS][NWAYS];   // position 0 is most recent

    tag_result_t expected_results[$];
    int src_idle_pct;
    int sink_idle_pct;
    int fail_count;

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic void clear_shadow();
        int s;
        int w;
        for (s = 0; s < SETS; s++)
        begin
            for (w = 0; w < NWAYS; w++)
            begin
                shadow_tag[w][s]   = '0;
                shadow_valid[w][s] = 1'b0;
                recency[s][w]      = way_idx_t'(NWAYS - 1 - w);
            end
        end
    endfunction

    // move the way at position pos to the most recent slot
    function automatic void promote(int s, int pos);
        way_idx_t w;
        int p;
        w = recency[s][pos];
        for (p = pos; p > 0; p--)
            recency[s][p] = recency[s][p-1];
        recency[s][0] = w;
    endfunction

    // expected result of one accepted request, with the shadow state update
    function automatic tag_result_t predict_access(mode_t m, logic [ADDR_BITS-1:0] a);
        tag_t        t;
        int          s;
        int          w;
        int          p;
        tag_result_t r;
        t = a[ADDR_BITS-1:OFF_W];
        s = int'(t[SET_W-1:0]);
        r = '0;
        if (m == MODE_WRITE)
        begin
            // allocate the least recent way, no search first
            w = int'(recency[s][NWAYS-1]);
            promote(s, NWAYS - 1);
            shadow_tag[w][s]   = t;
            shadow_valid[w][s] = 1'b1;
            r.hit = 1'b1;
            r.way = way_idx_t'(w);
        end
        else
        begin
            // lowest matching way wins
            for (w = 0; w < NWAYS && !r.hit; w++)
            begin
                if (shadow_valid[w][s] && shadow_tag[w][s] == t)
                begin
                    r.hit = 1'b1;
                    r.way = way_idx_t'(w);
                end
            end
            // only a read touches the recency order
            if (r.hit && m == MODE_READ)
            begin
                for (p = 0; p < NWAYS; p++)
                begin
                    if (recency[s][p] == r.way)
                    begin
                        promote(s, p);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // send one request item, with random idle cycles ahead of it
    task automatic send_access(mode_t m, logic [ADDR_BITS-1:0] a);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= m;
        req_ch.address <= a;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        expected_results.push_back(predict_access(m, a));
    endtask

    // check each result item against the oldest expectation
    always @(posedge clk)
    begin : check_results
        tag_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: hit=%0b way_index=%0d",
                             rsp_ch.hit, rsp_ch.way_index);
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.hit !== want.hit || rsp_ch.way_index !== want.way)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected hit=%0b way_index=%0d, ",
                                  "got hit=%0b way_index=%0d"},
                                 want.hit, want.way, rsp_ch.hit, rsp_ch.way_index);
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // fill one set with distinct tags, then hits, lookups and misses
    task automatic test_fill_and_hit();
        send_access(MODE_WRITE, 32'hFFFF_FFFF);
        send_access(MODE_WRITE, 32'h0000_0FC0);
        send_access(MODE_WRITE, 32'h8000_0FC0);
        send_access(MODE_WRITE, 32'h7FFF_FFC0);
        send_access(MODE_READ, 32'hFFFF_FFC0);
        send_access(MODE_LOOKUP, 32'h0000_0FC5);
        send_access(MODE_SPARE, 32'h8000_0FFF);
        send_access(MODE_READ, 32'h4000_0FC0);
        send_access(MODE_LOOKUP, 32'hC000_0FC0);
    endtask

    // lookups leave the order alone, reads and writes reorder it
    task automatic test_lru_order();
        send_access(MODE_LOOKUP, 32'h7FFF_FFC0);
        send_access(MODE_WRITE, 32'h1234_5FC0);
        send_access(MODE_READ, 32'h0000_0FC0);
        send_access(MODE_WRITE, 32'h5555_5FC0);
        send_access(MODE_READ, 32'h1234_5FC0);
    endtask

    // same tag in every way of a set, the lowest way must report
    task automatic test_duplicate_tags();
        send_access(MODE_WRITE, 32'h0000_0000);
        send_access(MODE_WRITE, 32'h0000_003F);
        send_access(MODE_WRITE, 32'h0000_0001);
        send_access(MODE_WRITE, 32'h0000_0020);
        send_access(MODE_READ, 32'h0000_0000);
        send_access(MODE_WRITE, 32'h0000_0010);
        send_access(MODE_LOOKUP, 32'h0000_003F);
    endtask

    // random traffic, mostly on a few hot sets so that tags get reused
    task automatic test_random_traffic(int count);
        int                   hot[HOT_SETS];
        int                   i;
        int                   s;
        int                   pick;
        logic                 reuse;
        mode_t                m;
        tag_t                 t;
        logic [OFF_W-1:0]     off;
        for (i = 0; i < HOT_SETS; i++)
            hot[i] = $urandom_range(SETS - 1);
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 75)
                s = hot[$urandom_range(HOT_SETS - 1)];
            else
                s = $urandom_range(SETS - 1);
            // any mode on any set, partly filled sets included
            pick = $urandom_range(99);
            if (pick < 40)
                m = MODE_READ;
            else if (pick < 60)
                m = MODE_LOOKUP;
            else if (pick < 70)
                m = MODE_SPARE;
            else
                m = MODE_WRITE;
            reuse = ($urandom_range(99) < ((m == MODE_WRITE) ? 25 : 65));
            if (reuse)
                t = shadow_tag[$urandom_range(NWAYS - 1)][s];
            else
                t = tag_t'({$urandom, set_t'(s)});
            off = OFF_W'($urandom);
            send_access(m, {t, off});
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.mode    = MODE_READ;
        req_ch.address = '0;
        fail_count     = 0;
        src_idle_pct   = 26;
        sink_idle_pct  = 61;
        clear_shadow();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_hit();
        test_lru_order();
        test_duplicate_tags();
        test_random_traffic(270);

        src_idle_pct  = 61;
        sink_idle_pct = 26;
        test_random_traffic(270);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(270);

        // drain the remaining result items
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ set_assoc_lru_tag_array.f @@
rtl/salru_pkg.sv
rtl/salru_if.sv
rtl/salru_way_logic.sv
rtl/set_assoc_lru_tag_array.sv
rtl/salru_checker.sv
test/tb_set_assoc_lru_tag_array.sv
